// File: rtl/pmq_pkg.sv
// Package for the priority message queue: sizes, slot entry layout and status codes.
// Used by the interfaces and the top level.
`timescale 1ns / 1ps

package pmq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MSG_W       = 32;
  localparam int PRI_W       = 8;
  localparam int IN_PRI_W    = 8;
  localparam int IN_MSG_W    = 32;
  localparam int OUT_MSG_W   = 32;
  localparam int STATUS_W    = 2;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int PTR_W       = IDX_W + 1;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [MSG_W-1:0]     msg_t;
  typedef logic [PRI_W-1:0]     pri_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [IN_PRI_W-1:0]  in_pri_t;
  typedef logic [IN_MSG_W-1:0]  in_msg_t;
  typedef logic [OUT_MSG_W-1:0] out_msg_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam ptr_t NULL_PTR = ptr_t'(QUEUE_DEPTH);

  typedef struct packed {
    msg_t msg;
    pri_t pri;
    ptr_t next;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/pmq_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on pmq_pkg for the payload types.
`timescale 1ns / 1ps

interface pmq_in_if;
  logic              valid;
  logic              ready;
  logic              opcode;
  pmq_pkg::in_pri_t  priority_req;
  pmq_pkg::in_msg_t  message_in;

  modport source (output valid, output opcode, output priority_req, output message_in,
                  input ready);
  modport sink (input valid, input opcode, input priority_req, input message_in,
                output ready);
endinterface

interface pmq_out_if;
  logic              valid;
  logic              ready;
  pmq_pkg::status_t  status;
  pmq_pkg::out_msg_t message_out;

  modport source (output valid, output status, output message_out, input ready);
  modport sink (input valid, input status, input message_out, output ready);
endinterface

// File: rtl/priority_message_queue.sv
// Top level of the priority message queue: request/result channels, list walker, slot memory.
// Depends on pmq_pkg, pmq_in_if, pmq_out_if and pmq_ram.
`timescale 1ns / 1ps

// The queue holds QUEUE_DEPTH messages in one slot memory, linked in ascending priority order.
// One request beat is taken at a time and gives exactly one result beat. A full insert, an
// empty remove or an insert into an empty list skips the walk; otherwise the walker
// reads one list entry per cycle through the single read port of the slot memory and
// visits at most QUEUE_DEPTH entries. A finished result waits in S_EMIT while the previous
// result still waits for the receiver.
// A new request is taken while the previous result still waits in the output register.
module priority_message_queue (
  input  logic           clk,
  input  logic           rst_n,
  pmq_in_if.sink         in_ch,
  pmq_out_if.source      out_ch
);
  import pmq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_IWALK = 3'd1;
  localparam logic [2:0] S_IFIX  = 3'd2;
  localparam logic [2:0] S_RWALK = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [QUEUE_DEPTH-1:0] used_r, used_nxt;
  ptr_t                   head_r, head_nxt;
  logic                   first_r, first_nxt;
  logic                   out_valid_r, out_valid_nxt;

  ptr_t    cur_r, cur_nxt;
  idx_t    prev_r, prev_nxt;
  entry_t  prev_ent_r, prev_ent_nxt;
  idx_t    free_r, free_nxt;
  pri_t    pri_r, pri_nxt;
  msg_t    msg_r, msg_nxt;
  status_t res_status_r, res_status_nxt;
  msg_t    res_msg_r, res_msg_nxt;
  status_t out_status_r, out_status_nxt;
  msg_t    out_msg_r, out_msg_nxt;

  logic   free_found;
  idx_t   free_idx;
  logic   ram_we, ram_re;
  idx_t   ram_waddr, ram_raddr;
  entry_t ram_wdata, rd_ent;
  logic   in_fire;

  function automatic logic is_link(ptr_t p);
    return p < NULL_PTR;
  endfunction

  pmq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_slots (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(rd_ent)
  );

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
      if (!used_r[k]) begin
        free_found = 1'b1;
        free_idx   = idx_t'(k);
      end
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.message_out = out_msg_t'(out_msg_r);

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    head_nxt       = head_r;
    first_nxt      = first_r;
    out_valid_nxt  = out_valid_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    prev_ent_nxt   = prev_ent_r;
    free_nxt       = free_r;
    pri_nxt        = pri_r;
    msg_nxt        = msg_r;
    res_status_nxt = res_status_r;
    res_msg_nxt    = res_msg_r;
    out_status_nxt = out_status_r;
    out_msg_nxt    = out_msg_r;
    ram_we         = 1'b0;
    ram_waddr      = free_r;
    ram_wdata      = '{msg: msg_r, pri: pri_r, next: NULL_PTR};
    ram_re         = 1'b0;
    ram_raddr      = cur_r[IDX_W-1:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_msg_nxt = '0;
          first_nxt   = 1'b1;
          cur_nxt     = head_r;
          ram_raddr   = head_r[IDX_W-1:0];
          if (in_ch.opcode == OP_INSERT) begin
            free_nxt = free_idx;
            pri_nxt  = in_ch.priority_req[PRI_W-1:0];
            msg_nxt  = in_ch.message_in[MSG_W-1:0];
            if (!free_found) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_EMIT;
            end else if (!is_link(head_r)) begin
              ram_we             = 1'b1;
              ram_waddr          = free_idx;
              ram_wdata          = '{msg: in_ch.message_in[MSG_W-1:0],
                                     pri: in_ch.priority_req[PRI_W-1:0], next: NULL_PTR};
              used_nxt[free_idx] = 1'b1;
              head_nxt           = ptr_t'(free_idx);
              res_status_nxt     = ST_OK;
              state_nxt          = S_EMIT;
            end else begin
              ram_re    = 1'b1;
              state_nxt = S_IWALK;
            end
          end else begin
            if (!is_link(head_r)) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_EMIT;
            end else begin
              ram_re    = 1'b1;
              state_nxt = S_RWALK;
            end
          end
        end
      end
      S_IWALK: begin
        if (rd_ent.pri >= pri_r) begin
          ram_we           = 1'b1;
          ram_wdata.next   = cur_r;
          used_nxt[free_r] = 1'b1;
          if (first_r) begin
            head_nxt       = ptr_t'(free_r);
            res_status_nxt = ST_OK;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_IFIX;
          end
        end else begin
          prev_nxt     = cur_r[IDX_W-1:0];
          prev_ent_nxt = rd_ent;
          first_nxt    = 1'b0;
          if (!is_link(rd_ent.next)) begin
            ram_we           = 1'b1;
            used_nxt[free_r] = 1'b1;
            state_nxt        = S_IFIX;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rd_ent.next[IDX_W-1:0];
            cur_nxt   = rd_ent.next;
          end
        end
      end
      S_IFIX: begin
        ram_we         = 1'b1;
        ram_waddr      = prev_r;
        ram_wdata      = '{msg: prev_ent_r.msg, pri: prev_ent_r.pri, next: ptr_t'(free_r)};
        res_status_nxt = ST_OK;
        state_nxt      = S_EMIT;
      end
      S_RWALK: begin
        if (is_link(rd_ent.next)) begin
          prev_nxt     = cur_r[IDX_W-1:0];
          prev_ent_nxt = rd_ent;
          first_nxt    = 1'b0;
          ram_re       = 1'b1;
          ram_raddr    = rd_ent.next[IDX_W-1:0];
          cur_nxt      = rd_ent.next;
        end else begin
          used_nxt[cur_r[IDX_W-1:0]] = 1'b0;
          res_msg_nxt                = rd_ent.msg;
          res_status_nxt             = ST_OK;
          state_nxt                  = S_EMIT;
          if (first_r) begin
            head_nxt = NULL_PTR;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = prev_r;
            ram_wdata = '{msg: prev_ent_r.msg, pri: prev_ent_r.pri, next: NULL_PTR};
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_msg_nxt    = res_msg_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      head_r      <= NULL_PTR;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      head_r      <= head_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    prev_ent_r   <= prev_ent_nxt;
    free_r       <= free_nxt;
    pri_r        <= pri_nxt;
    msg_r        <= msg_nxt;
    res_status_r <= res_status_nxt;
    res_msg_r    <= res_msg_nxt;
    out_status_r <= out_status_nxt;
    out_msg_r    <= out_msg_nxt;
  end

`ifndef NO_ASSERTIONS
  a_head_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> ((head_r == NULL_PTR) == (used_r == '0)))
    else $error("list head and busy bits disagree");

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r == NULL_PTR || is_link(head_r))
    else $error("list head out of range");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && res_status_r == ST_FULL) |-> (&used_r))
    else $error("full reported with a free slot");

  a_empty_only_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && res_status_r == ST_EMPTY) |-> (head_r == NULL_PTR))
    else $error("empty reported with a nonempty list");

  a_msg_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_msg_r == '0))
    else $error("message word not zero on an error beat");
`endif

endmodule

// File: rtl/pmq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pmq_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
